[hdl/bct_pkg.sv]
`default_nettype none

package bct_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 2;
    localparam int RESULT_W  = 3;
    localparam int POLL_W    = 6;
    localparam int RETRY_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REPLY   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;

    // send request codes
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CMD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // result codes
    localparam logic [RESULT_W-1:0] RES_OK          = 3'd0;
    localparam logic [RESULT_W-1:0] RES_BUSY        = 3'd1;
    localparam logic [RESULT_W-1:0] RES_CMDERR      = 3'd2;
    localparam logic [RESULT_W-1:0] RES_ADDRERR     = 3'd3;
    localparam logic [RESULT_W-1:0] RES_TIMEOUT     = 3'd4;
    localparam logic [RESULT_W-1:0] RES_UNCONFIRMED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd1;

    // protocol bytes and reset values
    localparam logic [BYTE_W-1:0]  QUERY_CODE      = 8'd222;
    localparam logic [BYTE_W-1:0]  STATUS_ACCEPTED = 8'd1;
    localparam logic [BYTE_W-1:0]  STATUS_BUSY     = 8'd3;
    localparam logic [POLL_W-1:0]  BUSY_LIMIT_RST  = 6'd30;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd2;

endpackage

`default_nettype wire

[hdl/bus_command_transaction.sv]
// Master side of a two-phase bus command, one event in, one result beat out.
// Input channel (i_in_valid / o_in_ready) carries events: start a command,
// a reply received from the board, or no reply within the timeout.
// Output channel (o_out_valid / i_out_ready) carries one result beat per
// event: what to send next (command frame or execute-status query, and
// whether to delay it), the final verdict with done set, or neither for an ignored event.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 busy poll limit, 1 error retry limit); write only while idle.
// The result beat is registered: it is valid in the cycle after the event is accepted.
// Throughput: one event per cycle while results drain; the whole decision is a
// single pass of compare-and-select logic between the event and the result register.
// When the receiver stalls, a new event is still taken in the same cycle
// that the waiting result is taken; otherwise o_in_ready drops until the
// result register drains.
// Reset (synchronous, active low) returns to idle, clears the target and
// held reply bytes and the poll counter, empties the result register and
// loads the limits with 30 and 2.
`default_nettype none

module bus_command_transaction (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_wr_en,
    input  wire  [bct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bct_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // event channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [bct_pkg::ACTION_W-1:0]        i_action,
    input  wire  [bct_pkg::BYTE_W-1:0]          i_board_addr,
    input  wire  [bct_pkg::BYTE_W-1:0]          i_command_code,
    input  wire  [bct_pkg::BYTE_W-1:0]          i_reply_addr,
    input  wire  [bct_pkg::BYTE_W-1:0]          i_reply_command,
    input  wire  [bct_pkg::BYTE_W-1:0]          i_reply_status,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [bct_pkg::REQ_W-1:0]           o_send_request,
    output logic                                o_send_delayed,
    output logic                                o_done_res,
    output logic [bct_pkg::RESULT_W-1:0]        o_result_code
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_WAIT_ACK = 2'd1;
    localparam logic [1:0] PH_POLL     = 2'd2;

    logic [bct_pkg::POLL_W-1:0]   r_busy_limit;
    logic [bct_pkg::RETRY_W-1:0]  r_retry_limit;

    logic [1:0]                   r_phase,       n_phase;
    logic [bct_pkg::BYTE_W-1:0]   r_target_addr, n_target_addr;
    logic [bct_pkg::BYTE_W-1:0]   r_target_cmd,  n_target_cmd;
    logic [bct_pkg::POLL_W-1:0]   r_poll_count,  n_poll_count;
    logic [bct_pkg::BYTE_W-1:0]   r_held_addr,   n_held_addr;
    logic [bct_pkg::BYTE_W-1:0]   r_held_cmd,    n_held_cmd;
    logic [bct_pkg::BYTE_W-1:0]   r_held_status, n_held_status;

    logic                         r_out_valid;
    logic [bct_pkg::REQ_W-1:0]    r_send_request, n_send_request;
    logic                         r_send_delayed, n_send_delayed;
    logic                         r_done_res,     n_done_res;
    logic [bct_pkg::RESULT_W-1:0] r_result_code,  n_result_code;

    logic                         in_beat;
    logic [bct_pkg::RESULT_W-1:0] verdict;
    logic                         held_busy;

    // result register can take a new beat when empty or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // held reply seen by this event (a reply outside idle overwrites it first)
    always_comb begin
        n_held_addr   = r_held_addr;
        n_held_cmd    = r_held_cmd;
        n_held_status = r_held_status;
        if (i_action == bct_pkg::ACT_REPLY && r_phase != PH_IDLE) begin
            n_held_addr   = i_reply_addr;
            n_held_cmd    = i_reply_command;
            n_held_status = i_reply_status;
        end
    end

    assign held_busy = (n_held_status == bct_pkg::STATUS_BUSY);

    // final verdict after polling
    always_comb begin
        if (held_busy) begin
            verdict = bct_pkg::RES_BUSY;
        end else if (n_held_addr != r_target_addr) begin
            verdict = bct_pkg::RES_ADDRERR;
        end else if (n_held_cmd == bct_pkg::QUERY_CODE) begin
            verdict = bct_pkg::RES_OK;
        end else begin
            verdict = bct_pkg::RES_UNCONFIRMED;
        end
    end

    // transaction decision for one event
    always_comb begin
        n_phase        = r_phase;
        n_target_addr  = r_target_addr;
        n_target_cmd   = r_target_cmd;
        n_poll_count   = r_poll_count;
        n_send_request = bct_pkg::REQ_NONE;
        n_send_delayed = 1'b0;
        n_done_res     = 1'b0;
        n_result_code  = bct_pkg::RES_OK;
        priority if (i_action == bct_pkg::ACT_START) begin
            n_target_addr  = i_board_addr;
            n_target_cmd   = i_command_code;
            n_poll_count   = '0;
            n_phase        = PH_WAIT_ACK;
            n_send_request = bct_pkg::REQ_CMD;
        end else if (i_action != bct_pkg::ACT_REPLY && i_action != bct_pkg::ACT_TIMEOUT) begin
            // unused action code: nothing to do
        end else if (r_phase == PH_WAIT_ACK) begin
            if (i_action == bct_pkg::ACT_TIMEOUT) begin
                n_phase       = PH_IDLE;
                n_done_res    = 1'b1;
                n_result_code = bct_pkg::RES_TIMEOUT;
            end else if (n_held_addr != r_target_addr) begin
                n_phase       = PH_IDLE;
                n_done_res    = 1'b1;
                n_result_code = bct_pkg::RES_ADDRERR;
            end else if (n_held_cmd != r_target_cmd
                         || n_held_status != bct_pkg::STATUS_ACCEPTED) begin
                n_phase       = PH_IDLE;
                n_done_res    = 1'b1;
                n_result_code = bct_pkg::RES_CMDERR;
            end else begin
                n_phase        = PH_POLL;
                n_poll_count   = '0;
                n_send_request = bct_pkg::REQ_QUERY;
                n_send_delayed = held_busy;
            end
        end else if (r_phase == PH_POLL) begin
            if ((i_action == bct_pkg::ACT_REPLY && held_busy && r_poll_count < r_busy_limit)
                || (i_action == bct_pkg::ACT_TIMEOUT
                    && r_poll_count < bct_pkg::POLL_W'(r_retry_limit))) begin
                n_poll_count   = r_poll_count + bct_pkg::POLL_W'(1);
                n_send_request = bct_pkg::REQ_QUERY;
                n_send_delayed = held_busy;
            end else begin
                n_phase       = PH_IDLE;
                n_done_res    = 1'b1;
                n_result_code = verdict;
            end
        end else begin
            // idle: replies and timeouts are ignored
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_limit  <= bct_pkg::BUSY_LIMIT_RST;
            r_retry_limit <= bct_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bct_pkg::CFG_BUSY_LIMIT:  r_busy_limit  <= i_cfg_data;
                bct_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[bct_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_target_addr <= '0;
            r_target_cmd  <= '0;
            r_poll_count  <= '0;
            r_held_addr   <= '0;
            r_held_cmd    <= '0;
            r_held_status <= '0;
        end else if (in_beat) begin
            r_phase       <= n_phase;
            r_target_addr <= n_target_addr;
            r_target_cmd  <= n_target_cmd;
            r_poll_count  <= n_poll_count;
            r_held_addr   <= n_held_addr;
            r_held_cmd    <= n_held_cmd;
            r_held_status <= n_held_status;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_send_request <= n_send_request;
            r_send_delayed <= n_send_delayed;
            r_done_res     <= n_done_res;
            r_result_code  <= n_result_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_request = r_send_request;
    assign o_send_delayed = r_send_delayed;
    assign o_done_res     = r_done_res;
    assign o_result_code  = r_result_code;

    // a finished beat never asks for a send
    a_done_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_send_request == bct_pkg::REQ_NONE)
        else $error("done beat carries a send request");

    // result code only meaningful with done
    a_code_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_result_code == bct_pkg::RES_OK)
        else $error("result code set without done");

    // a start beat yields a command frame request next cycle
    a_start_sends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_action == bct_pkg::ACT_START
        |=> o_out_valid && o_send_request == bct_pkg::REQ_CMD && r_phase == PH_WAIT_ACK)
        else $error("start did not issue a command frame");

    // finishing returns the transaction to idle
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_done_res || r_phase == PH_IDLE)
        else $error("transaction finished but not idle");

    // a delayed send only goes with a query
    a_delay_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_delayed |-> o_send_request == bct_pkg::REQ_QUERY)
        else $error("delay flagged without a query");

endmodule

`default_nettype wire

[tb/bct_tb_pkg.sv]
`default_nettype none

package bct_tb_pkg;

    import bct_pkg::*;

    // action code the block ignores in every phase
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT_ACK, PH_POLL} txn_phase_e;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   board_addr;
        logic [BYTE_W-1:0]   command_code;
        logic [BYTE_W-1:0]   reply_addr;
        logic [BYTE_W-1:0]   reply_command;
        logic [BYTE_W-1:0]   reply_status;
    } bus_event_t;

    typedef struct packed {
        logic [REQ_W-1:0]    send_request;
        logic                send_delayed;
        logic                done_res;
        logic [RESULT_W-1:0] result_code;
    } bus_result_t;

    class command_scoreboard;

        // limits and transaction state as the block should hold them
        logic [POLL_W-1:0]  busy_limit;
        logic [RETRY_W-1:0] retry_limit;
        txn_phase_e         phase;
        logic [BYTE_W-1:0]  target_addr;
        logic [BYTE_W-1:0]  target_cmd;
        logic [POLL_W-1:0]  poll_count;
        logic [BYTE_W-1:0]  held_addr;
        logic [BYTE_W-1:0]  held_cmd;
        logic [BYTE_W-1:0]  held_status;

        bus_result_t due_results[$];
        int          beat_count;
        int          mismatches;

        function new();
            busy_limit  = BUSY_LIMIT_RST;
            retry_limit = RETRY_LIMIT_RST;
            phase       = PH_IDLE;
            target_addr = '0;
            target_cmd  = '0;
            poll_count  = '0;
            held_addr   = '0;
            held_cmd    = '0;
            held_status = '0;
            beat_count  = 0;
            mismatches  = 0;
        endfunction

        function void write_limit(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
            if (index == CFG_BUSY_LIMIT)
                busy_limit = data;
            else if (index == CFG_RETRY_LIMIT)
                retry_limit = data[RETRY_W-1:0];
        endfunction

        // query beat, delayed while the held reply says busy
        function bus_result_t query_beat();
            bus_result_t r;
            r = '0;
            r.send_request = REQ_QUERY;
            r.send_delayed = (held_status == STATUS_BUSY);
            return r;
        endfunction

        function bus_result_t finish_with(logic [RESULT_W-1:0] code);
            bus_result_t r;
            r = '0;
            phase = PH_IDLE;
            r.done_res = 1'b1;
            r.result_code = code;
            return r;
        endfunction

        // verdict judged on whatever reply is held, stale or not
        function logic [RESULT_W-1:0] held_verdict();
            if (held_status == STATUS_BUSY)
                return RES_BUSY;
            if (held_addr != target_addr)
                return RES_ADDRERR;
            if (held_cmd == QUERY_CODE)
                return RES_OK;
            return RES_UNCONFIRMED;
        endfunction

        function bus_result_t advance_transaction(bus_event_t ev);
            bus_result_t r;
            bit          repoll;
            r = '0;

            // start abandons anything running, held reply stays
            if (ev.action == ACT_START) begin
                target_addr = ev.board_addr;
                target_cmd  = ev.command_code;
                poll_count  = '0;
                phase       = PH_WAIT_ACK;
                r.send_request = REQ_CMD;
                return r;
            end

            if ((ev.action != ACT_REPLY && ev.action != ACT_TIMEOUT) || phase == PH_IDLE)
                return r;

            if (ev.action == ACT_REPLY) begin
                held_addr   = ev.reply_addr;
                held_cmd    = ev.reply_command;
                held_status = ev.reply_status;
            end

            // acknowledgement of the command frame
            if (phase == PH_WAIT_ACK) begin
                if (ev.action == ACT_TIMEOUT)
                    r = finish_with(RES_TIMEOUT);
                else if (held_addr != target_addr)
                    r = finish_with(RES_ADDRERR);
                else if (held_cmd != target_cmd || held_status != STATUS_ACCEPTED)
                    r = finish_with(RES_CMDERR);
                else begin
                    phase      = PH_POLL;
                    poll_count = '0;
                    r = query_beat();
                end
                return r;
            end

            // polling, busy and retry share one counter
            if (ev.action == ACT_REPLY)
                repoll = (held_status == STATUS_BUSY) && (poll_count < busy_limit);
            else
                repoll = (poll_count < retry_limit);
            if (repoll) begin
                poll_count = poll_count + POLL_W'(1);
                return query_beat();
            end
            return finish_with(held_verdict());
        endfunction

        function void note_event(bus_event_t ev);
            due_results.push_back(advance_transaction(ev));
        endfunction

        function void check_beat(bus_result_t got);
            bus_result_t want;
            beat_count++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d unexpected: got %0d %0b %0b %0d",
                             beat_count, got.send_request, got.send_delayed, got.done_res,
                             got.result_code);
                return;
            end
            want = due_results.pop_front();
            if (got.send_request !== want.send_request || got.send_delayed !== want.send_delayed ||
                got.done_res !== want.done_res || got.result_code !== want.result_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: expected %0d %0b %0b %0d, got %0d %0b %0b %0d",
                             beat_count, want.send_request, want.send_delayed, want.done_res,
                             want.result_code, got.send_request, got.send_delayed,
                             got.done_res, got.result_code);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

    endclass

endpackage

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;

    import bct_pkg::*;
    import bct_tb_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES  = 240;
    localparam int PHASES           = 9;
    localparam int EVENTS_PER_PHASE = 214;

    // limit settings per phase, the last ones are random
    localparam logic [CFG_DAT_W-1:0] BUSY_PLAN  [6] = '{6'd0, 6'd63, 6'd1, 6'd5, 6'd63, 6'd0};
    localparam logic [CFG_DAT_W-1:0] RETRY_PLAN [6] = '{6'd0, 6'd63, 6'd1, 6'd17, 6'd48, 6'd15};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BUSY_LIMIT;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action = ACT_START;
    logic [BYTE_W-1:0]     board_addr = '0;
    logic [BYTE_W-1:0]     command_code = '0;
    logic [BYTE_W-1:0]     reply_addr = '0;
    logic [BYTE_W-1:0]     reply_command = '0;
    logic [BYTE_W-1:0]     reply_status = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [REQ_W-1:0]      send_request;
    logic                  send_delayed;
    logic                  done_res;
    logic [RESULT_W-1:0]   result_code;

    command_scoreboard sb = new();

    bit quiet_mode = 1'b0;
    bit hold_request = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int events_sent = 0;

    bus_command_transaction i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_board_addr    (board_addr),
        .i_command_code  (command_code),
        .i_reply_addr    (reply_addr),
        .i_reply_command (reply_command),
        .i_reply_status  (reply_status),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_send_request  (send_request),
        .o_send_delayed  (send_delayed),
        .o_done_res      (done_res),
        .o_result_code   (result_code)
    );

    // clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bus_event_t random_event();
        bus_event_t ev;
        ev.action        = ACTION_W'($urandom_range(0, 3));
        ev.board_addr    = BYTE_W'($urandom_range(0, 255));
        ev.command_code  = BYTE_W'($urandom_range(0, 255));
        ev.reply_addr    = BYTE_W'($urandom_range(0, 255));
        ev.reply_command = BYTE_W'($urandom_range(0, 255));
        ev.reply_status  = BYTE_W'($urandom_range(0, 255));
        return ev;
    endfunction

    function automatic bus_event_t make_event(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] ba,
                                              logic [BYTE_W-1:0] cc, logic [BYTE_W-1:0] ra,
                                              logic [BYTE_W-1:0] rc, logic [BYTE_W-1:0] rs);
        bus_event_t ev;
        ev = '{act, ba, cc, ra, rc, rs};
        return ev;
    endfunction

    // offer one event beat and wait for it to be taken
    task automatic send_event(bus_event_t ev);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= ev.action;
        board_addr    <= ev.board_addr;
        command_code  <= ev.command_code;
        reply_addr    <= ev.reply_addr;
        reply_command <= ev.reply_command;
        reply_status  <= ev.reply_status;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_event(ev);
        events_sent++;
    endtask

    // stop offering and let every expected beat drain
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_limits(logic [CFG_DAT_W-1:0] busy_data,
                                logic [CFG_DAT_W-1:0] retry_data);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BUSY_LIMIT;
        cfg_data  <= busy_data;
        @(posedge clk);
        sb.write_limit(CFG_BUSY_LIMIT, busy_data);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= retry_data;
        @(posedge clk);
        sb.write_limit(CFG_RETRY_LIMIT, retry_data);
        cfg_wr_en <= 1'b0;
    endtask

    // hand-picked corner cases under the reset limits
    task automatic run_directed();
        send_event(make_event(ACT_REPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_event(make_event(ACT_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // no acknowledgement
        send_event(make_event(ACT_START, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_event(make_event(ACT_TIMEOUT, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        // busy then missing reply then accepted
        send_event(make_event(ACT_START, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'hFF, 8'hFF, STATUS_ACCEPTED));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'hFF, QUERY_CODE, STATUS_BUSY));
        send_event(make_event(ACT_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'hFF, QUERY_CODE, STATUS_ACCEPTED));
        // acknowledgement from the wrong board
        send_event(make_event(ACT_START, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'h13, 8'h34, STATUS_ACCEPTED));
        // wrong echo, then status not accepted
        send_event(make_event(ACT_START, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'h12, 8'h35, STATUS_ACCEPTED));
        send_event(make_event(ACT_START, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00));
        // retries run out, verdict on the stale acknowledgement
        send_event(make_event(ACT_START, 8'hA5, 8'h5A, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'hA5, 8'h5A, STATUS_ACCEPTED));
        send_event(make_event(ACT_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // poll reply from another board
        send_event(make_event(ACT_START, 8'h3C, 8'h01, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'h3C, 8'h01, STATUS_ACCEPTED));
        send_event(make_event(ACT_REPLY, 8'h00, 8'h00, 8'h3D, QUERY_CODE, STATUS_ACCEPTED));
        // start while waiting for an acknowledgement
        send_event(make_event(ACT_START, 8'h77, 8'h88, 8'h00, 8'h00, 8'h00));
        send_event(make_event(ACT_START, 8'h66, 8'h99, 8'h00, 8'h00, 8'h00));
    endtask

    // one command with random content, mostly well formed
    task automatic run_transaction();
        bus_event_t        ev;
        logic [BYTE_W-1:0] tgt_addr;
        logic [BYTE_W-1:0] tgt_cmd;
        int                mode;
        int                steps;
        int                pick;
        int                busy_share;

        ev = random_event();
        ev.action = ACT_START;
        send_event(ev);
        tgt_addr = ev.board_addr;
        tgt_cmd  = ev.command_code;
        // normal board, board that stays busy, board that stops answering
        mode = $urandom_range(0, 5);
        busy_share = (mode == 1) ? 97 : (mode == 2) ? 10 : 55;
        steps = 0;

        while (sb.phase != PH_IDLE && steps < 120) begin
            ev = random_event();
            pick = $urandom_range(0, 99);
            if (sb.phase == PH_WAIT_ACK) begin
                if (pick < 75) begin
                    ev.action = ACT_REPLY;
                    ev.reply_addr = tgt_addr;
                    ev.reply_command = tgt_cmd;
                    ev.reply_status = STATUS_ACCEPTED;
                end else if (pick < 80) begin
                    ev.action = ACT_TIMEOUT;
                end else if (pick < 85) begin
                    ev.action = ACT_REPLY;
                    ev.reply_command = tgt_cmd;
                    ev.reply_status = STATUS_ACCEPTED;
                end else if (pick < 90) begin
                    ev.action = ACT_REPLY;
                    ev.reply_addr = tgt_addr;
                    ev.reply_status = STATUS_ACCEPTED;
                end else if (pick < 94) begin
                    ev.action = ACT_REPLY;
                    ev.reply_addr = tgt_addr;
                    ev.reply_command = tgt_cmd;
                end else if (pick < 97) begin
                    ev.action = ACT_UNUSED;
                end else begin
                    ev.action = ACT_START;
                end
            end else if (mode == 2 && pick < 80) begin
                ev.action = ACT_TIMEOUT;
            end else if (pick < busy_share) begin
                ev.action = ACT_REPLY;
                if ($urandom_range(0, 9) != 0)
                    ev.reply_addr = tgt_addr;
                if ($urandom_range(0, 1) != 0)
                    ev.reply_command = QUERY_CODE;
                ev.reply_status = STATUS_BUSY;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: ev.action = ACT_TIMEOUT;
                    2, 3, 4: begin
                        ev.action = ACT_REPLY;
                        ev.reply_addr = tgt_addr;
                        ev.reply_command = QUERY_CODE;
                        if ($urandom_range(0, 1) == 0 || ev.reply_status == STATUS_BUSY)
                            ev.reply_status = STATUS_ACCEPTED;
                    end
                    5: ev.action = ACT_REPLY;
                    6: begin
                        ev.action = ACT_REPLY;
                        ev.reply_addr = tgt_addr;
                    end
                    7: ev.action = ACT_UNUSED;
                    8: ev.action = ACT_START;
                    default: begin
                        ev.action = ACT_REPLY;
                        ev.reply_command = QUERY_CODE;
                        ev.reply_status = STATUS_ACCEPTED;
                    end
                endcase
            end
            if (ev.action == ACT_START) begin
                tgt_addr = ev.board_addr;
                tgt_cmd  = ev.command_code;
            end
            send_event(ev);
            steps++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        int gap;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            stall_left = (gap > 0) ? gap - 1 : 0;
            out_ready <= (gap == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result beats against the predicted ones
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_beat({send_request, send_delayed, done_res, result_code});
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        bus_event_t           ev;
        logic [CFG_DAT_W-1:0] busy_data;
        logic [CFG_DAT_W-1:0] retry_data;
        int                   phase_end;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        for (int p = 0; p < PHASES; p++) begin
            busy_data  = (p < 6) ? BUSY_PLAN[p] : 6'($urandom_range(0, 63));
            retry_data = (p < 6) ? RETRY_PLAN[p] : 6'($urandom_range(0, 63));
            write_limits(busy_data, retry_data);
            // fill the block while the receiver holds off
            if (p == 2 || p == 6) begin
                quiet_mode = 1'b1;
                hold_request = 1'b1;
            end
            phase_end = events_sent + EVENTS_PER_PHASE;
            while (events_sent < phase_end) begin
                if ($urandom_range(0, 19) == 0)
                    quiet_mode = !quiet_mode;
                // stray events while idle
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        ev = random_event();
                        ev.action = ACTION_W'($urandom_range(1, 3));
                        send_event(ev);
                    end
                end
                run_transaction();
            end
            settle();
        end

        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[bus_command_transaction.f]
hdl/bct_pkg.sv
hdl/bus_command_transaction.sv
tb/bct_tb_pkg.sv
tb/tb_top.sv
